/* rtl/ccp2u_pkg.sv */
// Package: shared types, code page selectors and lookup table for the code page transcoder.
`default_nettype none

package ccp2u_pkg;

    // Code page selector values
    localparam logic [1:0] CP_WIN1251 = 2'd0;
    localparam logic [1:0] CP_KOI8R   = 2'd1;
    localparam logic [1:0] CP_ISO8859 = 2'd2;

    // Byte and code point constants
    localparam logic [7:0]  UNDERSCORE    = 8'd95;
    localparam logic [15:0] CP_CAP_A      = 16'd1040;  // U+0410
    localparam logic [15:0] CP_CAP_IO     = 16'd1025;  // U+0401
    localparam logic [15:0] CP_SMALL_IO   = 16'd1105;  // U+0451
    localparam logic [15:0] CP_LOW_QUOTE  = 16'd8222;  // U+201E
    localparam logic [15:0] CP_LEFT_QUOTE = 16'd8220;  // U+201C
    localparam logic [15:0] CP_RIGHT_QUOTE = 16'd8221; // U+201D
    localparam logic [15:0] CP_NUMERO     = 16'd8470;  // U+2116
    localparam logic [15:0] CP_RAQUO      = 16'd187;   // U+00BB
    localparam logic [15:0] CP_TWO_BYTE_LIMIT = 16'h0800;

    // KOI8-R letters for bytes 0xC0..0xFF (all below U+0800, 11 bits)
    localparam logic [10:0] KOI_LETTERS [0:63] = '{
        11'h44E, 11'h430, 11'h431, 11'h446, 11'h434, 11'h435, 11'h444, 11'h433,
        11'h445, 11'h438, 11'h439, 11'h43A, 11'h43B, 11'h43C, 11'h43D, 11'h43E,
        11'h43F, 11'h44F, 11'h440, 11'h441, 11'h442, 11'h443, 11'h436, 11'h432,
        11'h44C, 11'h44B, 11'h437, 11'h448, 11'h44D, 11'h449, 11'h447, 11'h44A,
        11'h42E, 11'h410, 11'h411, 11'h426, 11'h414, 11'h415, 11'h424, 11'h413,
        11'h425, 11'h418, 11'h419, 11'h41A, 11'h41B, 11'h41C, 11'h41D, 11'h41E,
        11'h41F, 11'h42F, 11'h420, 11'h421, 11'h422, 11'h423, 11'h416, 11'h412,
        11'h42C, 11'h42B, 11'h417, 11'h428, 11'h42D, 11'h429, 11'h427, 11'h42A
    };

    // Encoded UTF-8 sequence for one source byte; bytes[0] goes out first
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      len;
    } utf8_seq_t;

endpackage : ccp2u_pkg

`default_nettype wire

/* rtl/ccp2u_enc.sv */
// Encoder: maps one code page byte to its Unicode code point and UTF-8 byte sequence.
`default_nettype none

module ccp2u_enc (
    input  wire logic [7:0]          in_byte,
    input  wire logic [1:0]          code_page,
    output ccp2u_pkg::utf8_seq_t     seq
);
    import ccp2u_pkg::*;

    logic [15:0] cp;
    logic [7:0]  iso_ofs;

    assign iso_ofs = in_byte - 8'd176;

    // Code point lookup, zero when the byte has no mapping
    always_comb begin
        cp = '0;
        unique case (code_page)
            CP_WIN1251: begin
                if (in_byte >= 8'd192) begin
                    cp = CP_CAP_A + {10'd0, in_byte[5:0]};
                end else begin
                    unique case (in_byte)
                        8'h84:   cp = CP_LOW_QUOTE;
                        8'h93:   cp = CP_LEFT_QUOTE;
                        8'h94:   cp = CP_RIGHT_QUOTE;
                        8'hA8:   cp = CP_CAP_IO;
                        8'hB8:   cp = CP_SMALL_IO;
                        8'hB9:   cp = CP_NUMERO;
                        8'hBB:   cp = CP_RAQUO;
                        default: cp = '0;
                    endcase
                end
            end
            CP_KOI8R: begin
                priority if (in_byte >= 8'd192) begin
                    cp = {5'd0, KOI_LETTERS[in_byte[5:0]]};
                end else if (in_byte == 8'hA3) begin
                    cp = CP_SMALL_IO;
                end else if (in_byte == 8'hB3) begin
                    cp = CP_CAP_IO;
                end else begin
                    cp = '0;
                end
            end
            CP_ISO8859: begin
                priority if (in_byte >= 8'd176 && in_byte <= 8'd239) begin
                    cp = CP_CAP_A + {10'd0, iso_ofs[5:0]};
                end else if (in_byte == 8'hA1) begin
                    cp = CP_CAP_IO;
                end else if (in_byte == 8'hF1) begin
                    cp = CP_SMALL_IO;
                end else begin
                    cp = '0;
                end
            end
            default: cp = '0;  // selector with no meaning: nothing mapped
        endcase
    end

    // UTF-8 packing
    always_comb begin
        seq.bytes = '0;
        seq.len   = 2'd1;
        priority if (!in_byte[7]) begin
            seq.bytes[0] = in_byte;
        end else if (cp == '0) begin
            seq.bytes[0] = UNDERSCORE;
        end else if (cp < CP_TWO_BYTE_LIMIT) begin
            seq.bytes[0] = {3'b110, cp[10:6]};
            seq.bytes[1] = {2'b10, cp[5:0]};
            seq.len      = 2'd2;
        end else begin
            seq.bytes[0] = {4'b1110, cp[15:12]};
            seq.bytes[1] = {2'b10, cp[11:6]};
            seq.bytes[2] = {2'b10, cp[5:0]};
            seq.len      = 2'd3;
        end
    end

endmodule : ccp2u_enc

`default_nettype wire

/* rtl/cyrillic_codepage_to_utf8.sv */
// Top level: Cyrillic single-byte code page to UTF-8 transcoder with stream ports.
`default_nettype none

// Transcodes a byte stream in Windows-1251, KOI8-R or ISO-8859-5 (selected by the
// 2-bit code page register) into UTF-8, one output byte per result request, with
// tlast marking the final byte of each character. Bytes 0..127 and unmapped high
// bytes (sent as an underscore) give one UTF-8 byte, Cyrillic letters two, and the
// typographic marks of Windows-1251 three; the one-byte result port, fed from a
// sequence register that drains one byte per cycle while the result side is ready,
// sets the rate. A new byte is taken in the cycle the previous character's last byte
// moves to the output register; bytes pass the sequence and then the output register.
// The code page register may only be written while no character is in flight.
module cyrillic_codepage_to_utf8 (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // Configuration write channel
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_data,    // code_page
    // Input stream
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,     // [7:0] in_byte
    // Result stream
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,     // [7:0] out_byte
    output logic            m_tlast      // last
);
    import ccp2u_pkg::*;

    logic [1:0]      code_page_reg;
    utf8_seq_t       enc_seq;
    logic [2:0][7:0] seq_bytes_reg;
    logic [1:0]      seq_cnt_reg;
    logic            m_tvalid_reg;
    logic [7:0]      m_tdata_reg;
    logic            m_tlast_reg;
    logic            out_load;
    logic            s_accept;

    // Configuration register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_page_reg <= CP_WIN1251;
        end else if (cfg_valid) begin
            code_page_reg <= cfg_data;
        end
    end

    // Lookup and UTF-8 packing
    ccp2u_enc u_enc (
        .in_byte   (s_tdata),
        .code_page (code_page_reg),
        .seq       (enc_seq)
    );

    // Handshake control
    assign out_load = !m_tvalid_reg || m_tready;
    assign s_tready = (seq_cnt_reg == 2'd0) || (seq_cnt_reg == 2'd1 && out_load);
    assign s_accept = s_tvalid && s_tready;

    // Sequence register: holds the bytes still to be sent for one character
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_cnt_reg <= 2'd0;
        end else if (s_accept) begin
            seq_cnt_reg <= enc_seq.len;
        end else if (out_load && seq_cnt_reg != 2'd0) begin
            seq_cnt_reg <= seq_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            seq_bytes_reg <= enc_seq.bytes;
        end else if (out_load) begin
            seq_bytes_reg <= {8'h00, seq_bytes_reg[2], seq_bytes_reg[1]};
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= (seq_cnt_reg != 2'd0);
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= seq_bytes_reg[0];
            m_tlast_reg <= (seq_cnt_reg == 2'd1);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef NO_ASSERTIONS
    // No new request while more than one byte of the current character remains
    a_no_accept_mid_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (seq_cnt_reg == 2'd2 || seq_cnt_reg == 2'd3) |-> !s_tready)
        else $error("input accepted with a multi-byte sequence pending");

    // A plain ASCII byte yields exactly one pending byte
    a_ascii_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !s_tdata[7]) |=> (seq_cnt_reg == 2'd1))
        else $error("ASCII byte did not load a one-byte sequence");

    // The final pending byte leaves with tlast set
    a_last_marks_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && seq_cnt_reg == 2'd1) |=> (m_tvalid && m_tlast))
        else $error("final byte of a character sent without tlast");

    // A byte leaving while more remain carries no tlast
    a_mid_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && (seq_cnt_reg == 2'd2 || seq_cnt_reg == 2'd3)) |=> (m_tvalid && !m_tlast))
        else $error("tlast set on a byte that is not the last one");
`endif

endmodule : cyrillic_codepage_to_utf8

`default_nettype wire

/* dv/cyrillic_codepage_to_utf8_tb.sv */
// Testbench for the Cyrillic code page to UTF-8 transcoder: directed tables, random text.
module cyrillic_codepage_to_utf8_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ccp2u_pkg::*;

    // Selector value with no table behind it
    localparam logic [1:0] CP_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 4;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLDOFF_CYCLES = 300;

    // KOI8-R letters, bytes 0xC0..0xFF
    localparam logic [10:0] KOI8R_LETTERS [0:63] = '{
        11'h44E, 11'h430, 11'h431, 11'h446, 11'h434, 11'h435, 11'h444, 11'h433,
        11'h445, 11'h438, 11'h439, 11'h43A, 11'h43B, 11'h43C, 11'h43D, 11'h43E,
        11'h43F, 11'h44F, 11'h440, 11'h441, 11'h442, 11'h443, 11'h436, 11'h432,
        11'h44C, 11'h44B, 11'h437, 11'h448, 11'h44D, 11'h449, 11'h447, 11'h44A,
        11'h42E, 11'h410, 11'h411, 11'h426, 11'h414, 11'h415, 11'h424, 11'h413,
        11'h425, 11'h418, 11'h419, 11'h41A, 11'h41B, 11'h41C, 11'h41D, 11'h41E,
        11'h41F, 11'h42F, 11'h420, 11'h421, 11'h422, 11'h423, 11'h416, 11'h412,
        11'h42C, 11'h42B, 11'h417, 11'h428, 11'h42D, 11'h429, 11'h427, 11'h42A
    };

    // One UTF-8 byte as it leaves the block
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } utf8_byte_t;

    logic       aclk;
    logic       aresetn;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_data;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;

    utf8_byte_t pending_utf8[$];
    logic [1:0] page_model;
    int         send_idle_pct;
    int         recv_idle_pct;
    int         holdoff_request;
    int         mismatch_count;
    int         bytes_in;
    int         bytes_out;
    int         quiet_cycles;
    int         seq_len_seen [1:3];
    bit         pages_used [0:3];

    cyrillic_codepage_to_utf8 dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Unicode code point of a high byte in the given page, zero when unmapped
    function automatic logic [15:0] code_point_of(input logic [1:0] page,
                                                  input logic [7:0] b);
        logic [15:0] wide;
        wide = {8'h00, b};
        case (page)
            CP_WIN1251: begin
                if (b >= 8'hC0) return 16'h0410 + (wide - 16'h00C0);
                case (b)
                    8'h84:   return 16'h201E;
                    8'h93:   return 16'h201C;
                    8'h94:   return 16'h201D;
                    8'hA8:   return 16'h0401;
                    8'hB8:   return 16'h0451;
                    8'hB9:   return 16'h2116;
                    8'hBB:   return 16'h00BB;
                    default: return 16'h0000;
                endcase
            end
            CP_KOI8R: begin
                if (b >= 8'hC0) return {5'b0, KOI8R_LETTERS[b[5:0]]};
                if (b == 8'hA3) return 16'h0451;
                if (b == 8'hB3) return 16'h0401;
                return 16'h0000;
            end
            CP_ISO8859: begin
                if (b >= 8'hB0 && b <= 8'hEF) return 16'h0410 + (wide - 16'h00B0);
                if (b == 8'hA1) return 16'h0401;
                if (b == 8'hF1) return 16'h0451;
                return 16'h0000;
            end
            default: return 16'h0000;
        endcase
    endfunction

    // Queue the UTF-8 bytes one source byte turns into
    task automatic predict_utf8(input logic [7:0] b);
        logic [15:0] cp;
        cp = code_point_of(page_model, b);
        if (b < 8'h80) begin
            pending_utf8.push_back('{b, 1'b1});
            seq_len_seen[1]++;
        end else if (cp == 16'h0000) begin
            pending_utf8.push_back('{UNDERSCORE, 1'b1});
            seq_len_seen[1]++;
        end else if (cp < 16'h0800) begin
            pending_utf8.push_back('{8'hC0 | {3'b0, cp[10:6]}, 1'b0});
            pending_utf8.push_back('{8'h80 | {2'b0, cp[5:0]}, 1'b1});
            seq_len_seen[2]++;
        end else begin
            pending_utf8.push_back('{8'hE0 | {4'b0, cp[15:12]}, 1'b0});
            pending_utf8.push_back('{8'h80 | {2'b0, cp[11:6]}, 1'b0});
            pending_utf8.push_back('{8'h80 | {2'b0, cp[5:0]}, 1'b1});
            seq_len_seen[3]++;
        end
    endtask

    // Predict on accepted source bytes, check accepted UTF-8 bytes
    always @(posedge aclk) begin
        utf8_byte_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) page_model = cfg_data;
            if (s_tvalid && s_tready) begin
                predict_utf8(s_tdata);
                bytes_in++;
            end
            if (m_tvalid && m_tready) begin
                bytes_out++;
                if (pending_utf8.size() == 0) begin
                    $error("unexpected result: out_byte %02h last %0b", m_tdata, m_tlast);
                    mismatch_count++;
                end else begin
                    want = pending_utf8.pop_front();
                    if (m_tdata !== want.data) begin
                        $error("out_byte mismatch: expected %02h, got %02h",
                               want.data, m_tdata);
                        mismatch_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last mismatch: expected %0b, got %0b", want.last, m_tlast);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Watchdog: too long without any request moving
    always @(posedge aclk) begin
        if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off on request
    initial begin
        int n;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (holdoff_request != 0) begin
                n = holdoff_request;
                holdoff_request = 0;
                m_tready <= 1'b0;
                repeat (n) @(negedge aclk);
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one source byte, idling cycle by cycle first; returns just after a falling edge
    task automatic send_source_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Stop offering and let every expected byte come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_utf8.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Write the code page register while nothing is in flight
    task automatic write_code_page(input logic [1:0] page);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= page;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        pages_used[page] = 1'b1;
    endtask

    // Random text: mostly high bytes, where the tables live
    function automatic logic [7:0] random_text_byte();
        if ($urandom_range(3) == 0) return 8'($urandom_range(0, 127));
        return 8'($urandom_range(128, 255));
    endfunction

    // ASCII extremes and unmapped high bytes under the reset page
    task automatic test_ascii_and_unmapped();
        send_source_byte(8'h00);
        send_source_byte(8'h7F);
        send_source_byte(8'h55);
        send_source_byte(8'h80);
        send_source_byte(8'hAA);
    endtask

    // Windows-1251: three-byte marks, Yo, raquo, letter range ends
    task automatic test_win1251_table();
        write_code_page(CP_WIN1251);
        send_source_byte(8'h84);
        send_source_byte(8'h93);
        send_source_byte(8'h94);
        send_source_byte(8'hB9);
        send_source_byte(8'hA8);
        send_source_byte(8'hB8);
        send_source_byte(8'hBB);
        send_source_byte(8'hC0);
        send_source_byte(8'hFF);
    endtask

    task automatic test_koi8r_table();
        write_code_page(CP_KOI8R);
        send_source_byte(8'hA3);
        send_source_byte(8'hB3);
        send_source_byte(8'hC0);
        send_source_byte(8'hFF);
        send_source_byte(8'h84);
    endtask

    task automatic test_iso8859_table();
        write_code_page(CP_ISO8859);
        send_source_byte(8'hA1);
        send_source_byte(8'hB0);
        send_source_byte(8'hEF);
        send_source_byte(8'hF0);
        send_source_byte(8'hF1);
    endtask

    // Selector 3: high bytes all unmapped, ASCII still passes
    task automatic test_unused_page();
        write_code_page(CP_UNUSED);
        send_source_byte(8'h41);
        send_source_byte(8'hC0);
        send_source_byte(8'hFF);
    endtask

    // Long result stall while the sender keeps offering, then a full drain
    task automatic test_backpressure();
        write_code_page(CP_WIN1251);
        send_idle_pct = 0;
        holdoff_request = HOLDOFF_CYCLES;
        for (int i = 0; i < 24; i++) begin
            case (i % 3)
                0: send_source_byte(8'hB9);
                1: send_source_byte(8'($urandom_range(192, 255)));
                default: send_source_byte(8'($urandom_range(0, 127)));
            endcase
        end
        wait_drained();
    endtask

    // Random text across every page, under three idling patterns
    task automatic test_random_text();
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 32; recv_idle_pct = 51; end
                1: begin send_idle_pct = 51; recv_idle_pct = 32; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int page = 0; page < 4; page++) begin
                write_code_page(2'(page));
                repeat (21) send_source_byte(random_text_byte());
            end
        end
    endtask

    // Test sequence
    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        cfg_valid = 1'b0;
        cfg_data = 2'd0;
        page_model = CP_WIN1251;
        send_idle_pct = 32;
        recv_idle_pct = 51;
        holdoff_request = 0;
        mismatch_count = 0;
        bytes_in = 0;
        bytes_out = 0;
        quiet_cycles = 0;
        seq_len_seen = '{0, 0, 0};
        pages_used = '{1'b0, 1'b0, 1'b0, 1'b0};

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_ascii_and_unmapped();
        test_win1251_table();
        test_koi8r_table();
        test_iso8859_table();
        test_unused_page();
        test_backpressure();
        test_random_text();

        wait_drained();
        repeat (8) @(negedge aclk);

        $display("Run covered %0d source bytes and %0d UTF-8 bytes (1/2/3-byte: %0d/%0d/%0d).",
                 bytes_in, bytes_out, seq_len_seen[1], seq_len_seen[2], seq_len_seen[3]);
        $display("Pages exercised: 1251=%0b KOI8-R=%0b 8859-5=%0b unused=%0b, long stall included.",
                 pages_used[0], pages_used[1], pages_used[2], pages_used[3]);
        if (mismatch_count == 0 && pending_utf8.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
